### hdl/qdot_pkg.sv
package qdot_pkg;

    localparam int BLOCK_VALUES = 32;
    localparam int HALF_VALUES  = BLOCK_VALUES / 2;
    localparam int IN_W         = 416;
    localparam int ACC_W        = 17;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam logic [31:0] QNAN    = 32'h7FC00000;
    localparam logic [30:0] INF_MAG = 31'h7F800000;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic [15:0]             wscale;
        logic [15:0]             ascale;
        logic                    last;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_AW:0]   count;
    } t_fifo_stat;

    // unrounded value: sig * 2^e, with special flags
    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic [47:0]        sig;
        logic signed [12:0] e;
    } t_unr;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] bits;
        logic [3:0]  k;
        logic [9:0]  m;
        k = 4'd0;
        m = h[9:0];
        if (h[14:10] == 5'h1f) begin
            bits = {h[15], 8'hff, h[9:0], 13'd0};
        end else if (h[14:10] != 5'd0) begin
            bits = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
        end else if (m == 10'd0) begin
            bits = {h[15], 31'd0};
        end else begin
            for (int i = 0; i < 10; i++) begin
                if (m[i]) k = 4'(i);
            end
            m = m << (4'd10 - k);
            bits = {h[15], 8'(k) + 8'd103, m, 13'd0};
        end
        return bits;
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return f[30:0] == INF_MAG;
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        return f[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] sig_of(input logic [31:0] f);
        return {f[30:23] != 8'd0, f[22:0]};
    endfunction

    // exponent of the significand's lsb
    function automatic logic signed [12:0] exp_of(input logic [31:0] f);
        logic signed [12:0] e;
        e = (f[30:23] == 8'd0) ? 13'sd1 : $signed({5'd0, f[30:23]});
        return e - 13'sd150;
    endfunction

    function automatic t_unr int_to_unr(input logic signed [ACC_W-1:0] a);
        t_unr u;
        logic [ACC_W-1:0] mag;
        mag    = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        u.nan  = 1'b0;
        u.inf  = 1'b0;
        u.zero = (a == '0);
        u.sign = a[ACC_W-1];
        u.sig  = 48'(mag);
        u.e    = 13'sd0;
        return u;
    endfunction

    function automatic t_unr mul_pre(input logic [31:0] a, input logic [31:0] b);
        t_unr u;
        u.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b))
                 || (is_zero(a) && is_inf(b));
        u.inf  = is_inf(a) || is_inf(b);
        u.zero = is_zero(a) || is_zero(b);
        u.sign = a[31] ^ b[31];
        u.sig  = sig_of(a) * sig_of(b);
        u.e    = exp_of(a) + exp_of(b);
        return u;
    endfunction

    function automatic t_unr add_pre(input logic [31:0] a, input logic [31:0] b);
        t_unr        u;
        logic [31:0] bg;
        logic [31:0] sm;
        logic [26:0] mb;
        logic [26:0] ms;
        logic [12:0] d;
        logic [4:0]  dc;
        logic        lost;
        logic [27:0] s;
        if (a[30:0] >= b[30:0]) begin
            bg = a;
            sm = b;
        end else begin
            bg = b;
            sm = a;
        end
        d    = 13'(exp_of(bg) - exp_of(sm));
        dc   = (d > 13'd27) ? 5'd27 : 5'(d);
        mb   = {sig_of(bg), 3'd0};
        ms   = {sig_of(sm), 3'd0};
        lost = (ms & ((27'd1 << dc) - 27'd1)) != 27'd0;
        ms   = (ms >> dc) | 27'(lost);
        s    = (a[31] == b[31]) ? (28'(mb) + 28'(ms)) : (28'(mb) - 28'(ms));
        u.nan = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]));
        u.inf = is_inf(a) || is_inf(b);
        u.sig = 48'(s);
        u.e   = exp_of(bg) - 13'sd3;
        if (u.inf) begin
            u.sign = is_inf(a) ? a[31] : b[31];
            u.zero = 1'b0;
        end else if (is_zero(a) && is_zero(b)) begin
            u.sign = a[31] & b[31];
            u.zero = 1'b1;
        end else begin
            u.zero = (s == 28'd0);
            u.sign = (s == 28'd0) ? 1'b0 : bg[31];
        end
        return u;
    endfunction

    // round to nearest even and pack
    function automatic logic [31:0] finish(input t_unr u);
        logic [5:0]         p;
        logic signed [12:0] sh;
        logic signed [12:0] shs;
        logic signed [12:0] ef;
        logic [5:0]         shc;
        logic [49:0]        ext;
        logic [24:0]        q;
        logic               g;
        logic               st;
        logic [33:0]        mag;
        p = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (u.sig[i]) p = 6'(i);
        end
        sh  = $signed({7'd0, p}) - 13'sd23;
        shs = -13'sd149 - u.e;
        if (shs > sh) sh = shs;
        ext = {2'b00, u.sig};
        if (sh <= 13'sd0) begin
            q = {1'b0, u.sig[23:0]} << 5'(-sh);
        end else begin
            shc = (sh > 13'sd49) ? 6'd49 : 6'(sh);
            q   = 25'(ext >> shc);
            g   = ext[shc - 6'd1];
            st  = (ext & ((50'd1 << (shc - 6'd1)) - 50'd1)) != 50'd0;
            q   = q + 25'(g & (st | q[0]));
        end
        ef  = sh + u.e + 13'sd149;
        mag = (34'(ef[9:0]) << 23) + 34'(q);
        if (u.nan) begin
            return QNAN;
        end else if (u.inf) begin
            return {u.sign, INF_MAG};
        end else if (u.zero) begin
            return {u.sign, 31'd0};
        end else if (mag >= 34'(INF_MAG)) begin
            return {u.sign, INF_MAG};
        end
        return {u.sign, mag[30:0]};
    endfunction

endpackage

### hdl/qdot_front.sv
module qdot_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [qdot_pkg::IN_W-1:0] i_s_axis_tdata,
    input  logic                     i_s_axis_tlast,
    output logic                     o_push,
    output qdot_pkg::t_job           o_job,
    input  logic                     i_full
);
    import qdot_pkg::*;

    logic                     r_v;
    logic signed [15:0]       r_part [4];
    logic signed [15:0]       n_part [4];
    logic [15:0]              r_ws;
    logic [15:0]              r_as;
    logic                     r_last;
    logic                     w_take;

    assign o_s_axis_tready = !r_v || !i_full;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_push          = r_v && !i_full;

    // four partial sums, each over four weight bytes (eight products)
    always_comb begin
        logic [7:0]         wb;
        logic signed [4:0]  lo;
        logic signed [4:0]  hi;
        logic signed [7:0]  alo;
        logic signed [7:0]  ahi;
        logic signed [12:0] plo;
        logic signed [12:0] phi;
        for (int g = 0; g < 4; g++) begin
            n_part[g] = 16'sd0;
            for (int jj = 0; jj < 4; jj++) begin
                wb  = i_s_axis_tdata[16 + 8*(g*4 + jj) +: 8];
                lo  = $signed({1'b0, wb[3:0]}) - 5'sd8;
                hi  = $signed({1'b0, wb[7:4]}) - 5'sd8;
                alo = $signed(i_s_axis_tdata[160 + 8*(g*4 + jj) +: 8]);
                ahi = $signed(i_s_axis_tdata[160 + 8*(g*4 + jj + HALF_VALUES) +: 8]);
                plo = 13'(lo) * 13'(alo);
                phi = 13'(hi) * 13'(ahi);
                n_part[g] = n_part[g] + 16'(plo) + 16'(phi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_take) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
        if (w_take) begin
            r_part <= n_part;
            r_ws   <= i_s_axis_tdata[15:0];
            r_as   <= i_s_axis_tdata[159:144];
            r_last <= i_s_axis_tlast;
        end
    end

    assign o_job.acc    = ACC_W'(r_part[0]) + ACC_W'(r_part[1])
                        + ACC_W'(r_part[2]) + ACC_W'(r_part[3]);
    assign o_job.wscale = r_ws;
    assign o_job.ascale = r_as;
    assign o_job.last   = r_last;

endmodule

### hdl/qdot_fifo.sv
module qdot_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qdot_pkg::t_job       i_job,
    input  logic                 i_pop,
    output qdot_pkg::t_job       o_head,
    output qdot_pkg::t_fifo_stat o_stat
);
    import qdot_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

### hdl/qdot_back.sv
module qdot_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qdot_pkg::t_job i_head,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [31:0]    o_m_axis_tdata
);
    import qdot_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CVT  = 9'b000000010,
        S_RNDI = 9'b000000100,
        S_MUL1 = 9'b000001000,
        S_RND1 = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_RND2 = 9'b001000000,
        S_ADD  = 9'b010000000,
        S_RNDA = 9'b100000000
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [31:0] r_dx;
    logic [31:0] r_dy;
    logic [31:0] r_t;
    t_unr        r_u;
    logic [31:0] r_sum;
    logic [31:0] r_out;
    logic        r_ovalid;
    logic [31:0] w_rnd;
    logic        w_oslot;

    assign o_pop           = (r_state == S_IDLE) && !i_empty;
    assign w_rnd           = finish(r_u);
    assign w_oslot         = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sum    <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_RNDA) && r_job.last && w_oslot) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: if (!i_empty) r_state <= S_CVT;
                S_CVT:  r_state <= S_RNDI;
                S_RNDI: r_state <= S_MUL1;
                S_MUL1: r_state <= S_RND1;
                S_RND1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_RND2;
                S_RND2: r_state <= S_ADD;
                S_ADD:  r_state <= S_RNDA;
                S_RNDA: begin
                    // a last beat waits for the output slot
                    if (!r_job.last) begin
                        r_sum   <= w_rnd;
                        r_state <= S_IDLE;
                    end else if (w_oslot) begin
                        r_sum    <= 32'd0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        case (r_state)
            S_IDLE: r_job <= i_head;
            S_CVT: begin
                r_u  <= int_to_unr(r_job.acc);
                r_dx <= half_to_single(r_job.wscale);
                r_dy <= half_to_single(r_job.ascale);
            end
            S_RNDI, S_RND1, S_RND2: r_t <= w_rnd;
            S_MUL1: r_u <= mul_pre(r_t, r_dx);
            S_MUL2: r_u <= mul_pre(r_t, r_dy);
            S_ADD:  r_u <= add_pre(r_sum, r_t);
            S_RNDA: if (r_job.last && w_oslot) r_out <= w_rnd;
            default: r_t <= r_t;
        endcase
    end

endmodule

### hdl/q4_q8_block_dot_product.sv
// Dot product of 4-bit weight blocks with 8-bit activation blocks, one
// 32-value block pair per input beat, accumulated per row in FP32 and sent
// out on the beat marked tlast. The front end takes a beat per cycle while
// the queue has room, forms the exact integer block sum and queues it (four
// entries); the back end then takes each block in turn: integer-to-float,
// scale by the weight scale, scale by the activation scale and add to the
// row sum, each through one shared round-to-nearest-even step. A new block
// is taken only once the last is done. NaN results come out as 0x7FC00000.
module q4_q8_block_dot_product (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // weight_scale, weight_nibbles_low, weight_nibbles_high, act_scale,
    // act_values_0, act_values_1, act_values_2, act_values_3
    input  logic [qdot_pkg::IN_W-1:0] i_s_axis_tdata,
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // dot_bits
    output logic [31:0]               o_m_axis_tdata
);
    import qdot_pkg::*;

    logic       w_push;
    logic       w_pop;
    t_job       w_job;
    t_job       w_head;
    t_fifo_stat w_stat;

    qdot_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_push          (w_push),
        .o_job           (w_job),
        .i_full          (w_stat.full)
    );

    qdot_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    qdot_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_empty         (w_stat.empty),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[30:23] == 8'hff)
         && (o_m_axis_tdata[22:0] != 23'd0)) |-> (o_m_axis_tdata == QNAN))
        else $error("non-canonical NaN on output");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.empty |-> !w_pop)
        else $error("pop from empty queue");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int  CLK_HALF   = 6;
    localparam int  CYCLE_MAX  = 600000;
    localparam int  DRAIN_WAIT = 60;
    localparam logic [31:0] CANON_NAN = 32'h7FC00000;

    typedef struct {
        logic [15:0] w_scale;
        logic [63:0] w_lo;
        logic [63:0] w_hi;
        logic [15:0] a_scale;
        logic [63:0] a_val [4];
        logic        last;
    } t_blk;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [qdot_pkg::IN_W-1:0] i_s_axis_tdata;
    logic                      i_s_axis_tlast;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [31:0]               o_m_axis_tdata;

    q4_q8_block_dot_product uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    logic [31:0] expected_dots [$];
    logic [31:0] row_sum;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          mismatches;
    int          dots_seen;
    int          blocks_sent;
    int          cycles;

    // ---------------- FP32 arithmetic on bit patterns ----------------

    function automatic logic [31:0] fp_round(input logic sgn, input logic [63:0] sig,
                                             input int e);
        int           p;
        int           sh;
        logic [127:0] ext;
        longint       q;
        longint       mag;
        logic         g;
        logic         st;
        p = 0;
        for (int i = 0; i < 64; i++) if (sig[i]) p = i;
        sh = p - 23;
        if (e + sh < -149) sh = -149 - e;
        ext = 128'(sig);
        if (sh <= 0) begin
            q = longint'(sig) <<< (-sh);
        end else if (sh > 100) begin
            q = 0;
        end else begin
            q  = longint'(ext >> sh);
            g  = ext[sh - 1];
            st = (ext & ((128'd1 << (sh - 1)) - 128'd1)) != 128'd0;
            if (g && (st || q[0])) q = q + 1;
        end
        // normal: hidden bit carries the exponent up by one; subnormal: E = -149
        mag = (longint'(e + sh + 149) <<< 23) + q;
        if (mag >= 64'h7F800000) return {sgn, 31'h7F800000};
        return {sgn, mag[30:0]};
    endfunction

    function automatic logic fp_nan(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function automatic logic fp_inf(input logic [31:0] f);
        return f[30:0] == 31'h7F800000;
    endfunction

    function automatic logic fp_zero(input logic [31:0] f);
        return f[30:0] == 0;
    endfunction

    function automatic logic [63:0] fp_sig(input logic [31:0] f);
        return (f[30:23] == 0) ? 64'(f[22:0]) : 64'({1'b1, f[22:0]});
    endfunction

    function automatic int fp_lsb_exp(input logic [31:0] f);
        return (f[30:23] == 0) ? -149 : int'(f[30:23]) - 150;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (fp_nan(a) || fp_nan(b)) return CANON_NAN;
        if ((fp_inf(a) && fp_zero(b)) || (fp_zero(a) && fp_inf(b))) return CANON_NAN;
        if (fp_inf(a) || fp_inf(b)) return {s, 31'h7F800000};
        if (fp_zero(a) || fp_zero(b)) return {s, 31'd0};
        return fp_round(s, fp_sig(a) * fp_sig(b), fp_lsb_exp(a) + fp_lsb_exp(b));
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] bg;
        logic [31:0] sm;
        logic [63:0] mb;
        logic [63:0] ms;
        logic [63:0] s;
        int          d;
        if (fp_nan(a) || fp_nan(b)) return CANON_NAN;
        if (fp_inf(a) && fp_inf(b)) return (a[31] == b[31]) ? a : CANON_NAN;
        if (fp_inf(a)) return a;
        if (fp_inf(b)) return b;
        if (fp_zero(a) && fp_zero(b)) return {a[31] & b[31], 31'd0};
        if (fp_zero(a)) return b;
        if (fp_zero(b)) return a;
        if (a[30:0] >= b[30:0]) begin
            bg = a; sm = b;
        end else begin
            bg = b; sm = a;
        end
        d  = fp_lsb_exp(bg) - fp_lsb_exp(sm);
        mb = fp_sig(bg) << 3;
        ms = fp_sig(sm) << 3;
        if (d >= 30) ms = 64'd1;  // whole small operand folds into sticky
        else if (d > 0) ms = (ms >> d) | 64'((ms & ((64'd1 << d) - 1)) != 0);
        s = (a[31] == b[31]) ? mb + ms : mb - ms;
        if (s == 0) return 32'd0;
        return fp_round(bg[31], s, fp_lsb_exp(bg) - 3);
    endfunction

    function automatic logic [31:0] half_bits_to_fp(input logic [15:0] h);
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:0] == 0) return {h[15], 31'd0};
        if (h[14:10] == 0) return fp_round(h[15], 64'(h[9:0]), -24);
        return fp_round(h[15], 64'({1'b1, h[9:0]}), int'(h[14:10]) - 25);
    endfunction

    // ---------------- block predictor ----------------

    function automatic int block_int_dot(input t_blk b);
        int          acc;
        logic [7:0]  wb;
        logic [7:0]  xl;
        logic [7:0]  xh;
        acc = 0;
        for (int j = 0; j < 16; j++) begin
            wb  = (j < 8) ? b.w_lo[8*j +: 8] : b.w_hi[8*(j-8) +: 8];
            xl  = b.a_val[j / 8][8*(j % 8) +: 8];
            xh  = b.a_val[(j + 16) / 8][8*((j + 16) % 8) +: 8];
            acc += (int'(wb[3:0]) - 8) * int'($signed(xl));
            acc += (int'(wb[7:4]) - 8) * int'($signed(xh));
        end
        return acc;
    endfunction

    task automatic accumulate_block(input t_blk b);
        int          acc;
        logic [31:0] t;
        acc = block_int_dot(b);
        t   = (acc == 0) ? 32'd0 : fp_round(acc < 0, 64'(acc < 0 ? -acc : acc), 0);
        t   = fp_mul(t, half_bits_to_fp(b.w_scale));
        t   = fp_mul(t, half_bits_to_fp(b.a_scale));
        row_sum = fp_add(row_sum, t);
        if (b.last) begin
            expected_dots.push_back(fp_nan(row_sum) ? CANON_NAN : row_sum);
            row_sum = 32'd0;
        end
    endtask

    // ---------------- clock, reset, counters ----------------

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("timeout after %0d cycles, %0d dots pending", cycles, expected_dots.size());
            $display("FAIL q4_q8_block_dot_product");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_left > 0) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // result checker
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            dots_seen <= dots_seen + 1;
            if (expected_dots.size() == 0) begin
                if (mismatches < 10) $display("unexpected dot beat %h", o_m_axis_tdata);
                mismatches <= mismatches + 1;
            end else begin
                want = expected_dots.pop_front();
                if (o_m_axis_tdata !== want) begin
                    if (mismatches < 10)
                        $display("dot mismatch: expected %h got %h", want, o_m_axis_tdata);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_block(input t_blk b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tlast  <= b.last;
        i_s_axis_tdata  <= {b.a_val[3], b.a_val[2], b.a_val[1], b.a_val[0],
                            b.a_scale, b.w_hi, b.w_lo, b.w_scale};
        do @(posedge i_clk); while (!o_s_axis_tready);
        accumulate_block(b);
        blocks_sent++;
    endtask

    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_all_dots();
        while (expected_dots.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_half();
        int r;
        r = $urandom_range(99);
        if (r < 80) return {1'($urandom), 5'($urandom_range(20, 8)), 10'($urandom)};
        if (r < 87) return {1'($urandom), 5'd0, 10'($urandom)};
        if (r < 89) return {1'($urandom), 5'h1F, 10'($urandom_range(1))};
        if (r < 93) return {1'($urandom), 5'($urandom_range(30, 26)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    function automatic t_blk rand_block(input logic last);
        t_blk b;
        b.w_scale = rand_half();
        b.a_scale = rand_half();
        b.w_lo    = {$urandom, $urandom};
        b.w_hi    = {$urandom, $urandom};
        for (int k = 0; k < 4; k++) b.a_val[k] = {$urandom, $urandom};
        b.last = last;
        return b;
    endfunction

    function automatic t_blk fill_block(input logic [15:0] ws, input logic [7:0] wbyte,
                                        input logic [15:0] as, input logic [7:0] abyte,
                                        input logic last);
        t_blk b;
        b.w_scale = ws;
        b.a_scale = as;
        b.w_lo    = {8{wbyte}};
        b.w_hi    = {8{wbyte}};
        for (int k = 0; k < 4; k++) b.a_val[k] = {8{abyte}};
        b.last = last;
        return b;
    endfunction

    task automatic send_rows(input int n_blocks);
        int left;
        left = 0;
        for (int i = 0; i < n_blocks; i++) begin
            if (left == 0) left = ($urandom_range(9) == 0) ? $urandom_range(16, 1)
                                                           : $urandom_range(6, 1);
            left--;
            send_block(rand_block(left == 0 || i == n_blocks - 1));
        end
    endtask

    task automatic test_directed();
        t_blk b;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_block(fill_block(16'h3C00, 8'h88, 16'h3C00, 8'h00, 1'b1)); // all zero
        send_block(fill_block(16'h3C00, 8'hFF, 16'h3C00, 8'h7F, 1'b1)); // 7 * 127
        send_block(fill_block(16'h3C00, 8'h00, 16'h3C00, 8'h80, 1'b1)); // -8 * -128
        send_block(fill_block(16'h3C00, 8'h00, 16'h3C00, 8'h7F, 1'b1));
        send_block(fill_block(16'h7BFF, 8'h00, 16'h7BFF, 8'h80, 1'b1)); // largest finite scales
        send_block(fill_block(16'hFBFF, 8'h00, 16'h7BFF, 8'h80, 1'b1)); // negative largest weight scale
        send_block(fill_block(16'h7C00, 8'hFF, 16'h3C00, 8'h01, 1'b1)); // inf scale
        send_block(fill_block(16'h7C00, 8'h88, 16'h3C00, 8'h55, 1'b1)); // inf * 0
        send_block(fill_block(16'h7E01, 8'h12, 16'h3C00, 8'h34, 1'b1)); // NaN scale
        send_block(fill_block(16'h3C00, 8'h12, 16'hFD55, 8'h34, 1'b1)); // neg NaN
        send_block(fill_block(16'h0001, 8'h9A, 16'h0001, 8'h03, 1'b1)); // subnormals
        send_block(fill_block(16'h03FF, 8'hF0, 16'h8001, 8'hC3, 1'b1));
        send_block(fill_block(16'h8000, 8'h88, 16'h3C00, 8'h00, 1'b1)); // -0 scale
        send_block(fill_block(16'h8000, 8'hFF, 16'h3C00, 8'h11, 1'b1));
        // +inf then -inf within one row
        send_block(fill_block(16'h7C00, 8'hFF, 16'h3C00, 8'h01, 1'b0));
        send_block(fill_block(16'hFC00, 8'hFF, 16'h3C00, 8'h01, 1'b1));
        // exact cancellation over a row
        send_block(fill_block(16'h4400, 8'hF9, 16'h3800, 8'h21, 1'b0));
        send_block(fill_block(16'hC400, 8'hF9, 16'h3800, 8'h21, 1'b1));
        // non-last blocks, then a last block
        send_block(fill_block(16'h3555, 8'h3A, 16'h2E66, 8'hE7, 1'b0));
        send_block(fill_block(16'h1234, 8'h5C, 16'h4321, 8'h19, 1'b0));
        b = rand_block(1'b1);
        send_block(b);
        b = fill_block(16'h0400, 8'h7E, 16'h0400, 8'hFE, 1'b1); // smallest normal
        send_block(b);
        go_idle();
        wait_all_dots();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_rows(n);
        go_idle();
        wait_all_dots();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        // keeps offering while output is held: queue fills, input stalls
        send_rows(40);
        go_idle();
        wait_all_dots();
        // mixed rate, sender pauses on full drain between rows
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        for (int i = 0; i < 10; i++) begin
            send_rows($urandom_range(6, 1));
            go_idle();
            wait_all_dots();
        end
    endtask

    initial begin
        cycles     = 0;
        hold_left  = 0;
        mismatches = 0;
        dots_seen  = 0;
        blocks_sent = 0;
        row_sum    = 32'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 250);
        test_random_phase(84, 0, 220);
        test_random_phase(0, 84, 220);
        test_random_phase(31, 31, 250);
        test_backpressure();
        test_random_phase(0, 0, 60);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d blocks over directed, random and stall phases; %0d dots checked",
                 blocks_sent, dots_seen);
        $display("%0d mismatches, %0d dots still pending", mismatches, expected_dots.size());
        if (mismatches == 0 && expected_dots.size() == 0) begin
            $display("PASS q4_q8_block_dot_product");
        end else begin
            $display("FAIL q4_q8_block_dot_product");
        end
        $finish;
    end

endmodule
